[hdl/srlb_pkg.sv]
// Shared widths, register codes and structs for the slew rate limiter bank.
// No dependencies; imported by every module except the generic RAM.
package srlb_pkg;

  localparam int KEY_W    = 32;
  localparam int TIME_W   = 32;
  localparam int SLOPE_W  = 32;
  localparam int FRAC_W   = 16;
  localparam int VAL_W    = 48;
  localparam int IDXO_W   = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;
  localparam int LIM_W    = 65;
  localparam int SUM_W    = 51;

  localparam logic [CFG_IDX_W-1:0] CFG_UP_SLOPE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWN_SLOPE = 1'd1;

  localparam logic signed [LIM_W-1:0] STEP_CAP = 65'sd562949953421312;

  typedef struct packed {
    logic [VAL_W-1:0]  held;
    logic [TIME_W-1:0] last;
  } limiter_word_t;

  typedef struct packed {
    logic hold;
    logic up_en;
    logic dn_en;
  } clamp_ctl_t;

endpackage

[hdl/slew_rate_limiter_bank_unit.sv]
// Top level of the slew rate limiter bank: pipeline control, state RAM, forwarding.
// Depends on srlb_pkg, srlb_ram, srlb_index, srlb_slope, srlb_clamp.
//
//   channel   signals                                        direction
//   request   in_valid, in_ready, request_key, time_tick     in
//   result    out_valid, out_ready, limited_value,
//             limiter_index                                  out
//   config    cfg_write, cfg_index, cfg_data                 in
//
// One request per cycle sustained while the output is not stalled; results pass through the stages below.
// Five register stages: input, key*reciprocal, state RAM read, slope multiply, output.
// Per-limiter state lives in one RAM; same-limiter requests back to back are forwarded.
// After reset every RAM address is swept to zero while in_ready is held low.
// A stalled output holds only the stages behind it that are full; bubbles still fill.
module slew_rate_limiter_bank_unit #(
  parameter int LIMITER_COUNT = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [srlb_pkg::KEY_W-1:0]        request_key,
  input  logic [srlb_pkg::TIME_W-1:0]       time_tick,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [srlb_pkg::VAL_W-1:0]        limited_value,
  output logic [srlb_pkg::IDXO_W-1:0]       limiter_index,
  input  logic                              cfg_write,
  input  logic [srlb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [srlb_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import srlb_pkg::*;

  localparam int IDX_W  = (LIMITER_COUNT > 1) ? $clog2(LIMITER_COUNT) : 1;
  localparam int WORD_W = $bits(limiter_word_t);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LIMITER_COUNT - 1);

  logic signed [SLOPE_W-1:0] up_slope;
  logic signed [SLOPE_W-1:0] down_slope;

  logic             clearing;
  logic [IDX_W-1:0] clr_addr;

  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  logic [KEY_W-1:0]  key1;
  logic [TIME_W-1:0] time1;

  logic [KEY_W-1:0]  key2;
  logic [TIME_W-1:0] time2;
  logic [IDX_W-1:0]  idx2;

  logic [KEY_W-1:0]  key3;
  logic [TIME_W-1:0] time3;
  logic [IDX_W-1:0]  idx3;
  logic              byp_v;
  limiter_word_t     byp_word;
  limiter_word_t     ram_rdata;
  limiter_word_t     cap_word;
  logic [TIME_W-1:0] last3;
  logic [TIME_W-1:0] dt3;
  clamp_ctl_t        ctl_next;

  logic [KEY_W-1:0]        key4;
  logic [TIME_W-1:0]       time4;
  logic [IDX_W-1:0]        idx4;
  logic [VAL_W-1:0]        held4;
  clamp_ctl_t              ctl4;
  logic signed [LIM_W-1:0] up_lim;
  logic signed [LIM_W-1:0] dn_lim;
  logic [VAL_W-1:0]        held_fw;
  logic [VAL_W-1:0]        result;

  logic [IDX_W-1:0] idx5;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  limiter_word_t    ram_wdata;
  logic             upd_we;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      up_slope   <= '0;
      down_slope <= '0;
    end else if (cfg_write) begin
      if (cfg_index == CFG_UP_SLOPE) begin
        up_slope <= $signed(cfg_data[SLOPE_W-1:0]);
      end else if (cfg_index == CFG_DOWN_SLOPE) begin
        down_slope <= $signed(cfg_data[SLOPE_W-1:0]);
      end
    end
  end

  // sweep the state RAM after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == LAST_IDX) begin
        clearing <= 1'b0;
      end
    end
  end

  assign rdy5     = !out_valid || out_ready;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1 && !clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
      byp_v     <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid && in_ready;
      if (rdy2) v2 <= v1;
      if (rdy3) begin
        v3    <= v2;
        byp_v <= upd_we && (idx4 == idx2);
      end
      if (rdy4) v4 <= v3;
      if (rdy5) out_valid <= v4;
    end
  end

  // stage 1: input register
  always_ff @(posedge clk) begin
    if (rdy1) begin
      key1  <= request_key;
      time1 <= time_tick;
    end
  end

  // stage 2: limiter select
  srlb_index #(
    .LIMITER_COUNT(LIMITER_COUNT),
    .IDX_W(IDX_W)
  ) u_index (
    .clk(clk),
    .en(rdy2),
    .key_in(key1),
    .key_out(key2),
    .idx(idx2)
  );

  always_ff @(posedge clk) begin
    if (rdy2) begin
      time2 <= time1;
    end
  end

  // stage 3: state read, elapsed ticks
  always_ff @(posedge clk) begin
    if (rdy3) begin
      key3     <= key2;
      time3    <= time2;
      idx3     <= idx2;
      byp_word <= ram_wdata;
    end
  end

  assign cap_word = byp_v ? byp_word : ram_rdata;
  assign last3    = (v4 && (idx4 == idx3)) ? time4 : cap_word.last;
  assign dt3      = time3 - last3;

  always_comb begin
    ctl_next.hold  = (dt3 == '0);
    ctl_next.up_en = (up_slope != '0);
    ctl_next.dn_en = (down_slope != '0);
  end

  srlb_slope u_slope (
    .clk(clk),
    .en(rdy4),
    .dt(dt3),
    .up_slope(up_slope),
    .down_slope(down_slope),
    .up_lim(up_lim),
    .dn_lim(dn_lim)
  );

  // stage 4: clamp and write back
  always_ff @(posedge clk) begin
    if (rdy4) begin
      key4  <= key3;
      time4 <= time3;
      idx4  <= idx3;
      held4 <= cap_word.held;
      ctl4  <= ctl_next;
    end
  end

  assign held_fw = (out_valid && (idx5 == idx4)) ? limited_value : held4;

  srlb_clamp u_clamp (
    .ctl(ctl4),
    .held(held_fw),
    .key(key4),
    .up_lim(up_lim),
    .dn_lim(dn_lim),
    .result(result)
  );

  assign upd_we = v4 && rdy5;

  always_comb begin
    ram_we = clearing || upd_we;
    if (clearing) begin
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_waddr      = idx4;
      ram_wdata.held = result;
      ram_wdata.last = time4;
    end
  end

  srlb_ram #(
    .WIDTH(WORD_W),
    .DEPTH(LIMITER_COUNT),
    .AW(IDX_W)
  ) u_state_ram (
    .clk(clk),
    .we(ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re(rdy3),
    .raddr(idx2),
    .rdata(ram_rdata)
  );

  // stage 5: output register
  always_ff @(posedge clk) begin
    if (rdy5) begin
      limited_value <= result;
      idx5          <= idx4;
    end
  end

  assign limiter_index = IDXO_W'(idx5);

endmodule

[hdl/srlb_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered read.
// Read returns the old word when both ports hit the same address. No dependencies.
module srlb_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/srlb_index.sv]
// Limiter select: request key modulo LIMITER_COUNT by reciprocal multiply and correction.
// One register stage (product and key copy); depends on srlb_pkg.
module srlb_index #(
  parameter int LIMITER_COUNT = 16,
  parameter int IDX_W = (LIMITER_COUNT > 1) ? $clog2(LIMITER_COUNT) : 1
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [srlb_pkg::KEY_W-1:0] key_in,
  output logic [srlb_pkg::KEY_W-1:0] key_out,
  output logic [IDX_W-1:0]          idx
);
  import srlb_pkg::*;

  localparam int LOG_N       = (LIMITER_COUNT > 1) ? $clog2(LIMITER_COUNT) : 0;
  localparam int RECIP_SHIFT = KEY_W + LOG_N;
  localparam int RECIP_W     = KEY_W + 1;
  localparam int PROD_W      = KEY_W + RECIP_W;
  localparam int REM_W       = IDX_W + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((64'd1 << RECIP_SHIFT) / LIMITER_COUNT);
  localparam logic [KEY_W-1:0] DIVISOR = KEY_W'(LIMITER_COUNT);
  localparam logic [REM_W-1:0] DIVISOR_R = REM_W'(LIMITER_COUNT);

  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] prod_next;
  logic [KEY_W-1:0]  quot;
  logic [KEY_W-1:0]  rem_full;
  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  rem_fix;

  assign prod_next = PROD_W'(key_in) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      prod    <= prod_next;
      key_out <= key_in;
    end
  end

  // quotient estimate is exact or one low
  assign quot     = KEY_W'(prod >> RECIP_SHIFT);
  assign rem_full = key_out - KEY_W'(quot * DIVISOR);
  assign rem      = rem_full[REM_W-1:0];
  assign rem_fix  = (rem >= DIVISOR_R) ? (rem - DIVISOR_R) : rem;
  assign idx      = rem_fix[IDX_W-1:0];

endmodule

[hdl/srlb_slope.sv]
// Slope limits: up and down slope registers times elapsed ticks, registered.
// Depends on srlb_pkg.
module srlb_slope (
  input  logic                                clk,
  input  logic                                en,
  input  logic [srlb_pkg::TIME_W-1:0]         dt,
  input  logic signed [srlb_pkg::SLOPE_W-1:0] up_slope,
  input  logic signed [srlb_pkg::SLOPE_W-1:0] down_slope,
  output logic signed [srlb_pkg::LIM_W-1:0]   up_lim,
  output logic signed [srlb_pkg::LIM_W-1:0]   dn_lim
);
  import srlb_pkg::*;

  logic signed [TIME_W:0] dt_s;

  assign dt_s = $signed({1'b0, dt});

  always_ff @(posedge clk) begin
    if (en) begin
      up_lim <= LIM_W'(up_slope * dt_s);
      dn_lim <= LIM_W'(down_slope * dt_s);
    end
  end

endmodule

[hdl/srlb_clamp.sv]
// Clamp logic: compares the error against the slope limits, steps with saturation.
// Combinational; depends on srlb_pkg.
module srlb_clamp (
  input  srlb_pkg::clamp_ctl_t              ctl,
  input  logic [srlb_pkg::VAL_W-1:0]        held,
  input  logic [srlb_pkg::KEY_W-1:0]        key,
  input  logic signed [srlb_pkg::LIM_W-1:0] up_lim,
  input  logic signed [srlb_pkg::LIM_W-1:0] dn_lim,
  output logic [srlb_pkg::VAL_W-1:0]        result
);
  import srlb_pkg::*;

  function automatic logic [VAL_W-1:0] sat_step(input logic [VAL_W-1:0] base,
                                                input logic signed [LIM_W-1:0] lim);
    logic signed [LIM_W-1:0] step;
    logic signed [SUM_W-1:0] sum;
    logic [VAL_W-1:0]        res;
    if (lim > STEP_CAP) begin
      step = STEP_CAP;
    end else if (lim < -STEP_CAP) begin
      step = -STEP_CAP;
    end else begin
      step = lim;
    end
    sum = $signed({{(SUM_W-VAL_W){1'b0}}, base}) + $signed(step[SUM_W-1:0]);
    if (sum[SUM_W-1]) begin
      res = '0;
    end else if (|sum[SUM_W-2:VAL_W]) begin
      res = '1;
    end else begin
      res = sum[VAL_W-1:0];
    end
    return res;
  endfunction

  logic [VAL_W-1:0]        target;
  logic signed [VAL_W:0]   err;
  logic signed [LIM_W-1:0] err_x;
  logic                    up_hit;
  logic                    dn_hit;
  logic [VAL_W-1:0]        up_val;
  logic [VAL_W-1:0]        dn_val;

  assign target = {key, {FRAC_W{1'b0}}};
  assign err    = $signed({1'b0, target}) - $signed({1'b0, held});
  assign err_x  = LIM_W'(err);
  assign up_hit = ctl.up_en && (err_x > up_lim);
  assign dn_hit = ctl.dn_en && (err_x < dn_lim);
  assign up_val = sat_step(held, up_lim);
  assign dn_val = sat_step(held, dn_lim);

  always_comb begin
    priority if (ctl.hold) begin
      result = held;
    end else if (up_hit) begin
      result = up_val;
    end else if (dn_hit) begin
      result = dn_val;
    end else begin
      result = target;
    end
  end

endmodule

[verif/slew_rate_limiter_bank_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for slew_rate_limiter_bank_unit: holds a copy of the limiter bank
// and compares every result against it. Depends on srlb_pkg and the unit's RTL.

class slew_scoreboard;
  localparam int LIMITERS = 16;

  typedef struct packed {
    logic [srlb_pkg::VAL_W-1:0]  value;
    logic [srlb_pkg::IDXO_W-1:0] index;
  } limit_result_t;

  logic [srlb_pkg::VAL_W-1:0]           held_value [LIMITERS];
  logic [srlb_pkg::TIME_W-1:0]          last_tick [LIMITERS];
  logic signed [srlb_pkg::SLOPE_W-1:0]  rise_slope;
  logic signed [srlb_pkg::SLOPE_W-1:0]  fall_slope;
  limit_result_t                        pending_limits [$];
  int                                   failures;

  function new();
    for (int i = 0; i < LIMITERS; i++) begin
      held_value[i] = '0;
      last_tick[i] = '0;
    end
    rise_slope = '0;
    fall_slope = '0;
    failures = 0;
  endfunction

  function void set_slopes(logic [31:0] rise, logic [31:0] fall);
    rise_slope = rise;
    fall_slope = fall;
  endfunction

  function int pending();
    return pending_limits.size();
  endfunction

  // Move the held value by a slope step: cap the step, then saturate to 48 bits.
  function logic [srlb_pkg::VAL_W-1:0] stepped_value(logic [srlb_pkg::VAL_W-1:0] cur,
                                                     longint step);
    longint cap;
    longint ceiling;
    longint sum;
    cap = longint'(1) << 49;
    ceiling = longint'({16'h0, {srlb_pkg::VAL_W{1'b1}}});
    if (step > cap) step = cap;
    if (step < -cap) step = -cap;
    sum = longint'({16'h0, cur}) + step;
    if (sum < 0) return '0;
    if (sum > ceiling) return {srlb_pkg::VAL_W{1'b1}};
    return sum[srlb_pkg::VAL_W-1:0];
  endfunction

  function void note_request(logic [31:0] key, logic [31:0] tick);
    int                          idx;
    logic [31:0]                 dt;
    logic [srlb_pkg::VAL_W-1:0]  cur;
    logic [srlb_pkg::VAL_W-1:0]  nxt;
    longint                      err;
    longint                      rise_lim;
    longint                      fall_lim;
    limit_result_t               res;
    idx = int'(key % LIMITERS);
    dt = tick - last_tick[idx];
    last_tick[idx] = tick;
    cur = held_value[idx];
    if (dt == 0) begin
      nxt = cur;
    end else begin
      err = longint'({16'h0, key, 16'h0}) - longint'({16'h0, cur});
      rise_lim = longint'(rise_slope) * longint'({32'h0, dt});
      fall_lim = longint'(fall_slope) * longint'({32'h0, dt});
      if (rise_slope != 0 && err > rise_lim) nxt = stepped_value(cur, rise_lim);
      else if (fall_slope != 0 && err < fall_lim) nxt = stepped_value(cur, fall_lim);
      else nxt = {key, 16'h0};
    end
    held_value[idx] = nxt;
    res.value = nxt;
    res.index = idx[srlb_pkg::IDXO_W-1:0];
    pending_limits.push_back(res);
  endfunction

  function void check_result(logic [srlb_pkg::VAL_W-1:0] value,
                             logic [srlb_pkg::IDXO_W-1:0] index);
    limit_result_t want;
    if (pending_limits.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("unexpected result: value=%h index=%0d", value, index);
      return;
    end
    want = pending_limits.pop_front();
    if (want.value !== value || want.index !== index) begin
      failures++;
      if (failures <= 10)
        $display("mismatch: expected value=%h index=%0d, got value=%h index=%0d",
                 want.value, want.index, value, index);
    end
  endfunction
endclass

module slew_rate_limiter_bank_unit_tb;
  localparam int LIMITERS = 16;
  localparam int PHASE_REQUESTS = 260;
  localparam int STALL_LIMIT = 4000;

  logic                              clk;
  logic                              rst = 1'b1;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic [srlb_pkg::KEY_W-1:0]        request_key = '0;
  logic [srlb_pkg::TIME_W-1:0]       time_tick = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic [srlb_pkg::VAL_W-1:0]        limited_value;
  logic [srlb_pkg::IDXO_W-1:0]       limiter_index;
  logic                              cfg_write = 1'b0;
  logic [srlb_pkg::CFG_IDX_W-1:0]    cfg_index = srlb_pkg::CFG_UP_SLOPE;
  logic [srlb_pkg::CFG_DATA_W-1:0]   cfg_data = '0;

  slew_scoreboard sb = new();
  int             send_idle_pct = 0;
  int             recv_idle_pct = 0;
  int             stall_cycles = 0;

  slew_rate_limiter_bank_unit #(
    .LIMITER_COUNT(LIMITERS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .request_key(request_key),
    .time_tick(time_tick),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .limited_value(limited_value),
    .limiter_index(limiter_index),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(limited_value, limiter_index);
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("slew_rate_limiter_bank_unit verification failed");
      $finish;
    end
  end

  task automatic send_request(input logic [31:0] key, input logic [31:0] tick);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    request_key <= key;
    time_tick <= tick;
    do @(posedge clk); while (!in_ready);
    sb.note_request(key, tick);
  endtask

  // Drop valid and hold until every expected result is back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic set_slopes(input logic [31:0] rise, input logic [31:0] fall);
    cfg_write <= 1'b1;
    cfg_index <= srlb_pkg::CFG_UP_SLOPE;
    cfg_data <= rise;
    @(posedge clk);
    cfg_index <= srlb_pkg::CFG_DOWN_SLOPE;
    cfg_data <= fall;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_slopes(rise, fall);
  endtask

  task automatic random_request();
    int          idx;
    int          delta;
    logic [31:0] base;
    logic [31:0] key;
    logic [31:0] tick;
    int          pick;
    idx = $urandom_range(LIMITERS - 1);
    pick = $urandom_range(99);
    if (pick < 40) begin
      key = $urandom;
    end else if (pick < 85) begin
      delta = $urandom_range(2000) - 1000;
      base = sb.held_value[idx][47:16] + delta;
      key = base;
    end else if (pick < 93) begin
      key = 32'h0;
    end else begin
      key = 32'hFFFF_FFFF;
    end
    key[3:0] = idx[3:0];
    pick = $urandom_range(99);
    if (pick < 10) tick = sb.last_tick[idx];
    else if (pick < 60) tick = sb.last_tick[idx] + $urandom_range(1, 8);
    else if (pick < 80) tick = sb.last_tick[idx] + $urandom_range(1, 100000);
    else tick = $urandom;
    send_request(key, tick);
  endtask

  initial begin
    logic [31:0] rise;
    logic [31:0] fall;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 32;
    recv_idle_pct = 84;

    set_slopes(32'h0, 32'h0);
    send_request(32'h0000_0000, 32'h0000_0000);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'h0000_0010, 32'h0000_0005);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFF, 32'h0000_0003);
    drain_results();

    set_slopes(32'h0001_0000, 32'hFFFF_0000);
    send_request(32'h0000_1000, 32'h0000_0007);
    send_request(32'hFFFF_FFFF, 32'h0000_0004);
    send_request(32'h0000_000F, 32'h0000_0006);
    send_request(32'h0000_1000, 32'h0000_0007);
    send_request(32'h0000_0012, 32'h0000_0001);
    drain_results();

    set_slopes(32'h7FFF_FFFF, 32'h8000_0000);
    send_request(32'hFFFF_FFF0, 32'h8000_0000);
    send_request(32'h0000_0000, 32'h0000_0000);
    send_request(32'h5555_AAA5, 32'hAAAA_5555);
    drain_results();

    set_slopes(32'h0, 32'h7FFF_FFFF);
    send_request(32'h0000_0004, 32'hFFFF_FFFF);
    drain_results();

    set_slopes(32'h8000_0000, 32'h0);
    send_request(32'h0000_0014, 32'h1000_0000);
    send_request(32'h0000_0013, 32'h0000_0010);
    drain_results();

    for (int p = 0; p < 6; p++) begin
      send_idle_pct = (p < 2) ? 32 : (p < 4) ? 84 : 0;
      recv_idle_pct = (p < 2) ? 84 : (p < 4) ? 32 : 0;
      case (p)
        0: begin
          rise = $urandom_range(1, 32'h00FF_FFFF);
          fall = -$urandom_range(1, 32'h00FF_FFFF);
        end
        1: begin
          rise = 32'h0;
          fall = -$urandom_range(1, 32'h0FFF_FFFF);
        end
        2: begin
          rise = $urandom_range(1, 32'h0FFF_FFFF);
          fall = 32'h0;
        end
        3: begin
          rise = $urandom;
          fall = $urandom;
        end
        4: begin
          rise = 32'h7FFF_FFFF;
          fall = 32'h8000_0000;
        end
        default: begin
          rise = $urandom_range(1, 32'h0004_0000);
          fall = -$urandom_range(1, 32'h0004_0000);
        end
      endcase
      set_slopes(rise, fall);
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        random_request();
        if (p == 1 && n == PHASE_REQUESTS / 2) drain_results();
      end
      drain_results();
    end

    repeat (16) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("slew_rate_limiter_bank_unit verification clean");
    end else begin
      $display("slew_rate_limiter_bank_unit verification failed");
    end
    $finish;
  end
endmodule
